/* src/pfsa_pkg.sv */
`default_nettype none
package pfsa_pkg;

	localparam int FRAME_W = 14;
	localparam int COUNT_W = 15;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_INIT  = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_INVALID  = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;
	localparam logic [1:0] STS_OVERFLOW = 2'd3;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [FRAME_W-1:0] frame_t;

	typedef struct packed {
		logic [1:0] op;
		frame_t     frame;
	} pfsa_in_t;

	typedef struct packed {
		logic [1:0] status;
		frame_t     frame_out;
		count_t     frames_left;
	} pfsa_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_INIT
	} state_t;

endpackage
`default_nettype wire

/* src/pfsa_core.sv */
`default_nettype none
module pfsa_core #(
	parameter int unsigned MAX_FRAMES = 16384
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfsa_pkg::count_t  total,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pfsa_pkg::pfsa_in_t in_data,
	input  wire logic              out_free,
	output logic                   res_valid,
	output pfsa_pkg::pfsa_out_t    res_data
);
	import pfsa_pkg::*;

	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam logic [16:0] MAX_V = 17'(MAX_FRAMES);

	// free frame stack and free marks
	logic [AW-1:0] stack_mem [MAX_FRAMES];
	logic          mark_mem  [MAX_FRAMES];

	state_t        state_q, state_d;
	logic [1:0]    op_q;
	frame_t        frame_q;
	count_t        depth_q, depth_d;
	count_t        active_q, active_d;
	count_t        walk_q, walk_d;
	logic          init_q, init_d;
	logic [AW-1:0] stack_rd_q;
	logic          mark_rd_q;

	logic          in_fire;
	count_t        total_clamped;
	count_t        depth_m1;
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [AW-1:0] st_wdata;
	logic          mk_we;
	logic [AW-1:0] mk_waddr;
	logic          mk_wdata;
	logic [1:0]    status;
	logic [AW-1:0] got;

	assign in_fire = in_valid && in_ready;
	assign total_clamped = ({2'b00, total} > MAX_V) ? COUNT_W'(MAX_V) : total;
	assign depth_m1 = depth_q - 1'b1;

	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		active_d  = active_q;
		walk_d    = walk_q;
		init_d    = init_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		st_we     = 1'b0;
		st_waddr  = AW'(depth_q);
		st_wdata  = AW'(frame_q);
		mk_we     = 1'b0;
		mk_waddr  = AW'(frame_q);
		mk_wdata  = 1'b0;
		status    = STS_INVALID;
		got       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.op == OP_INIT && !init_q && total != '0) begin
						active_d = total_clamped;
						walk_d   = '0;
						state_d  = S_INIT;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			S_INIT: begin
				mk_we    = 1'b1;
				mk_waddr = AW'(walk_q);
				mk_wdata = (walk_q != '0);
				st_we    = (walk_q != '0);
				st_waddr = AW'(walk_q - 1'b1);
				st_wdata = AW'(walk_q);
				if (walk_q == active_q - 1'b1) begin
					depth_d = walk_q;
					init_d  = 1'b1;
					state_d = S_EXEC;
				end else begin
					walk_d = walk_q + 1'b1;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_ALLOC: begin
						if (!init_q || depth_q == '0) begin
							status = STS_EMPTY;
						end else begin
							depth_d = depth_m1;
							if (17'(stack_rd_q) >= 17'(active_q)) begin
								status = STS_EMPTY;
							end else begin
								status   = STS_OK;
								got      = stack_rd_q;
								mk_we    = 1'b1;
								mk_waddr = stack_rd_q;
								mk_wdata = 1'b0;
							end
						end
					end
					OP_FREE: begin
						if (!init_q || {1'b0, frame_q} >= active_q || frame_q == '0) begin
							status = STS_INVALID;
						end else if (mark_rd_q) begin
							status = STS_INVALID;
						end else begin
							mk_we    = 1'b1;
							mk_wdata = 1'b1;
							if (depth_q >= active_q) begin
								status = STS_OVERFLOW;
							end else begin
								status  = STS_OK;
								st_we   = 1'b1;
								depth_d = depth_q + 1'b1;
							end
						end
					end
					OP_INIT: begin
						status = init_q ? STS_OK : STS_INVALID;
					end
					default: begin
						status = STS_INVALID;
					end
				endcase
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end else begin
					st_we   = 1'b0;
					mk_we   = 1'b0;
					depth_d = depth_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_data.status      = status;
	assign res_data.frame_out   = FRAME_W'(got);
	assign res_data.frames_left = depth_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			depth_q  <= '0;
			active_q <= '0;
			walk_q   <= '0;
			init_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			depth_q  <= depth_d;
			active_q <= active_d;
			walk_q   <= walk_d;
			init_q   <= init_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= in_data.op;
			frame_q <= in_data.frame;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			stack_rd_q <= stack_mem[AW'(depth_m1)];
		end
		if (st_we) begin
			stack_mem[st_waddr] <= st_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mark_rd_q <= mark_mem[AW'(in_data.frame)];
		end
		if (mk_we) begin
			mark_mem[mk_waddr] <= mk_wdata;
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> depth_q < active_q)
		else $error("stack depth reached managed frame count");

	a_uninit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!init_q |-> depth_q == '0)
		else $error("stack not empty before init");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> walk_q < active_q)
		else $error("init walk ran past frame count");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted beat not processed");

	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && op_q == OP_ALLOC && status == STS_OK |-> got != '0)
		else $error("reserved frame handed out");
`endif

endmodule
`default_nettype wire

/* src/page_frame_stack_allocator_top.sv */
`default_nettype none
// channel | direction | payload                         | handshake
// in      | input     | pfsa_in_t  (op, frame)          | in_valid / in_ready
// out     | output    | pfsa_out_t (status, frame_out,  | out_valid / out_ready
//         |           |             frames_left)        |
// cfg     | input     | frame total, 15 bits            | cfg_valid / cfg_ready
//
// alloc, free, unused op and repeated or rejected init take, per beat,
// one stack/mark memory read then the read-modify-write with the result
// a first init walks the memories one frame a cycle, over the clamped frame total
// reset clears control state only; the memories are filled by init, no clearing pass
// one output register holds a finished result; the core waits with its writes
// while that register is full and not being drained
module page_frame_stack_allocator_top #(
	parameter int unsigned MAX_FRAMES = 16384
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pfsa_pkg::pfsa_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pfsa_pkg::pfsa_out_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire pfsa_pkg::count_t    cfg_data
);
	import pfsa_pkg::*;

	count_t    total_q;
	logic      out_valid_q;
	pfsa_out_t out_q;
	logic      out_free;
	logic      res_valid;
	pfsa_out_t res_data;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res_data;
		end
	end

	pfsa_core #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.total    (total_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_free (out_free),
		.res_valid(res_valid),
		.res_data (res_data)
	);

endmodule
`default_nettype wire
